[design/bras_pkg.sv]
`default_nettype none

package bras_pkg;

    // Internal index and length width: holds any index, length, block size or block end.
    localparam int IW = 12;

    typedef logic [1:0] t_opcode;

    localparam t_opcode OP_WRITE = 2'd0;
    localparam t_opcode OP_ADD   = 2'd1;
    localparam t_opcode OP_SUM   = 2'd2;
    localparam t_opcode OP_NONE  = 2'd3;

    typedef logic [0:0] t_cfg_index;

    localparam t_cfg_index CFG_ARRAY_LENGTH = 1'd0;
    localparam t_cfg_index CFG_BLOCK_SIZE   = 1'd1;

    // Handshake between the sequencer and the divider.
    typedef struct packed {
        logic          start;
        logic [9:0]    dividend;
        logic [IW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic          done;
        logic [9:0]    quot;
        logic [IW-1:0] rem;
    } t_div_rsp;

endpackage

`default_nettype wire

[design/bras_ram.sv]
`default_nettype none

module bras_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[design/bras_div.sv]
`default_nettype none

module bras_div
    import bras_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic [3:0]    r_cnt;
    logic [9:0]    r_quot;
    logic [IW-1:0] r_rem;
    logic [IW-1:0] r_div;
    logic          r_done;
    logic [IW-1:0] shifted;
    logic          take;

    // One quotient bit per cycle, restoring form.
    assign shifted = {r_rem[IW-2:0], r_quot[9]};
    assign take    = (shifted >= r_div);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= 4'd10;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd1) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= i_req.dividend;
            r_rem  <= '0;
            r_div  <= i_req.divisor;
        end else if (r_cnt != '0) begin
            r_rem  <= take ? (shifted - r_div) : shifted;
            r_quot <= {r_quot[8:0], take};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

[design/block_range_add_sum.sv]
// block_range_add_sum: array of up to MAX_LEN 64-bit elements split into blocks,
// each block with a pending add and a running sum.
// Input channel (i_valid / o_ready) takes one request: write element, range add,
// or range sum. Output channel (o_valid / i_ready) returns one result for a range
// sum and for any bad request (sum 0, error set); good writes and adds return none.
// Configuration: i_cfg_we writes array_length (index 0) or block_size (index 1);
// either write starts a clearing pass over all stores.
// Sequence: after the accept cycle a bit-serial divider finds the block index.
// A write then reads the stores (S_WRD) and writes them back (S_WWR). A range walk
// reads each block's stores, streams each element of a partly covered block and
// drains it, writes the block stores back for an add, and steps to the next block.
// The element store has one read and one write port, so partial blocks stream
// one element a cycle; block stores are read-modify-written one block at a time.
// Requests are handled one at a time; o_ready is high only between requests.
// Reset (i_rst_n low, synchronous) loads array_length 1024 and block_size 32
// and runs a clearing pass over max(MAX_LEN, MAX_BLOCKS) addresses with o_ready low.
// A result waits in the output register while the receiver stalls; the next
// request is taken meanwhile and only a second result holds the sequencer.
`default_nettype none

module block_range_add_sum
    import bras_pkg::*;
#(
    parameter int MAX_LEN    = 1024,
    parameter int MAX_BLOCKS = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_opcode,
    input  wire logic [9:0]         i_left_index,
    input  wire logic [9:0]         i_right_index,
    input  wire logic signed [31:0] i_operand_value,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [63:0]      o_range_sum,
    output logic                    o_range_error,
    input  wire logic               i_cfg_we,
    input  wire logic [0:0]         i_cfg_index,
    input  wire logic [10:0]        i_cfg_data
);

    localparam int AW    = $clog2(MAX_LEN);
    localparam int BW    = $clog2(MAX_BLOCKS);
    localparam int CLR_N = (MAX_LEN > MAX_BLOCKS) ? MAX_LEN : MAX_BLOCKS;
    localparam int CW    = $clog2(CLR_N);
    localparam logic [IW-1:0] LEN_CAP = (MAX_LEN < 2047) ? IW'(MAX_LEN) : IW'(2047);
    localparam logic [IW:0]   MB_M1   = (IW+1)'(MAX_BLOCKS - 1);

    typedef enum logic [11:0] {
        S_CLR  = 12'b0000_0000_0001,
        S_IDLE = 12'b0000_0000_0010,
        S_DIV  = 12'b0000_0000_0100,
        S_WRD  = 12'b0000_0000_1000,
        S_WWR  = 12'b0000_0001_0000,
        S_BLK  = 12'b0000_0010_0000,
        S_BRD  = 12'b0000_0100_0000,
        S_ELEM = 12'b0000_1000_0000,
        S_DRN  = 12'b0001_0000_0000,
        S_BWR  = 12'b0010_0000_0000,
        S_NEXT = 12'b0100_0000_0000,
        S_RES  = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Configuration and effective geometry.
    logic [10:0]   r_alen;
    logic [10:0]   r_bsz;
    logic [IW-1:0] r_n;
    logic [IW-1:0] r_bs;
    logic [IW-1:0] n_n;
    logic [IW-1:0] n_bs;
    logic [IW-1:0] alen_ext;
    logic [IW-1:0] bs_base;
    logic [IW:0]   minbs_num;
    logic [IW-1:0] minbs;

    // Request and walk state.
    t_opcode        r_op;
    logic [IW-1:0]  r_l;
    logic [IW-1:0]  r_r;
    logic [31:0]    r_c;
    logic [IW-1:0]  r_start;
    logic [BW-1:0]  r_blk;
    logic [IW-1:0]  r_lo;
    logic [IW-1:0]  r_hi;
    logic [IW-1:0]  r_len;
    logic [IW-1:0]  r_i;
    logic           r_full;
    logic [63:0]    r_pend;
    logic [63:0]    r_sum;
    logic [63:0]    r_prod;
    logic [63:0]    r_acc;
    logic           r_ev;
    logic [AW-1:0]  r_ea;
    logic [CW-1:0]  r_clr_cnt;
    logic           r_ovalid;
    logic [63:0]    r_res_sum;
    logic           r_res_err;
    logic [63:0]    r_osum;
    logic           r_oerr;

    logic           accept;
    logic           in_bad;
    logic [IW-1:0]  in_l;
    logic [IW-1:0]  in_r;
    logic [63:0]    c64;
    logic [IW-1:0]  end_raw;
    logic [IW-1:0]  blk_end;
    logic [IW-1:0]  blk_lo;
    logic [IW-1:0]  blk_hi;
    logic           blk_full;
    logic [IW-1:0]  next_start;
    logic signed [IW+32:0] prod;
    logic           out_load;

    // Memory ports.
    logic           elem_we;
    logic [AW-1:0]  elem_waddr;
    logic [63:0]    elem_wdata;
    logic [AW-1:0]  elem_raddr;
    logic [63:0]    elem_rdata;
    logic           pend_we;
    logic           sum_we;
    logic [BW-1:0]  blk_waddr;
    logic [63:0]    pend_wdata;
    logic [63:0]    sum_wdata;
    logic [63:0]    pend_rdata;
    logic [63:0]    sum_rdata;
    logic [63:0]    old_val;

    t_div_req div_req;
    t_div_rsp div_rsp;

    // Effective length and block size.
    assign alen_ext  = {1'b0, r_alen};
    assign n_n       = (alen_ext == '0) ? IW'(1) : ((alen_ext > LEN_CAP) ? LEN_CAP : alen_ext);
    assign bs_base   = (r_bsz == '0) ? IW'(1) : {1'b0, r_bsz};
    assign minbs_num = {1'b0, r_n} + MB_M1;
    assign minbs     = IW'(minbs_num / MAX_BLOCKS);
    assign n_bs      = (bs_base < minbs) ? minbs : bs_base;

    assign in_l    = {2'b00, i_left_index};
    assign in_r    = {2'b00, i_right_index};
    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign c64     = {{32{r_c[31]}}, r_c};

    always_comb begin
        in_bad = 1'b0;
        unique case (i_opcode)
            OP_WRITE:       in_bad = (in_l >= r_n);
            OP_ADD, OP_SUM: in_bad = (in_l > in_r) || (in_r >= r_n);
            default:        in_bad = 1'b0;
        endcase
    end

    // Block geometry for the current block.
    assign end_raw    = r_start + r_bs - IW'(1);
    assign blk_end    = (end_raw > (r_n - IW'(1))) ? (r_n - IW'(1)) : end_raw;
    assign blk_lo     = (r_start > r_l) ? r_start : r_l;
    assign blk_hi     = (blk_end < r_r) ? blk_end : r_r;
    assign blk_full   = (r_l <= r_start) && (r_r >= blk_end);
    assign next_start = r_start + r_bs;
    assign prod       = $signed(r_c) * $signed({1'b0, r_len});

    assign div_req.start    = accept && !in_bad && (i_opcode != OP_NONE);
    assign div_req.dividend = i_left_index;
    assign div_req.divisor  = r_bs;

    assign out_load = (r_state == S_RES) && (!r_ovalid || i_ready);
    assign old_val  = elem_rdata + pend_rdata;

    bras_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Memory write and read selection.
    always_comb begin
        elem_we    = 1'b0;
        elem_waddr = r_ea;
        elem_wdata = '0;
        pend_we    = 1'b0;
        sum_we     = 1'b0;
        blk_waddr  = r_blk;
        pend_wdata = '0;
        sum_wdata  = '0;
        if (r_state == S_CLR) begin
            elem_we    = (32'(r_clr_cnt) < MAX_LEN);
            elem_waddr = AW'(r_clr_cnt);
            pend_we    = (32'(r_clr_cnt) < MAX_BLOCKS);
            sum_we     = (32'(r_clr_cnt) < MAX_BLOCKS);
            blk_waddr  = BW'(r_clr_cnt);
        end else if (r_state == S_WWR) begin
            elem_we    = 1'b1;
            elem_waddr = AW'(r_l);
            elem_wdata = c64 - pend_rdata;
            sum_we     = 1'b1;
            sum_wdata  = sum_rdata + (c64 - old_val);
        end else if (r_state == S_BWR) begin
            sum_we     = 1'b1;
            sum_wdata  = r_sum + r_prod;
            pend_we    = r_full;
            pend_wdata = r_pend + c64;
        end else if (r_ev && (r_op == OP_ADD)) begin
            elem_we    = 1'b1;
            elem_wdata = elem_rdata + c64;
        end
    end

    assign elem_raddr = (r_state == S_ELEM) ? AW'(r_i) : AW'(r_l);

    bras_ram #(.WIDTH(64), .DEPTH(MAX_LEN)) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (elem_we),
        .i_waddr (elem_waddr),
        .i_wdata (elem_wdata),
        .i_raddr (elem_raddr),
        .o_rdata (elem_rdata)
    );

    bras_ram #(.WIDTH(64), .DEPTH(MAX_BLOCKS)) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (pend_we),
        .i_waddr (blk_waddr),
        .i_wdata (pend_wdata),
        .i_raddr (r_blk),
        .o_rdata (pend_rdata)
    );

    bras_ram #(.WIDTH(64), .DEPTH(MAX_BLOCKS)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (blk_waddr),
        .i_wdata (sum_wdata),
        .i_raddr (r_blk),
        .o_rdata (sum_rdata)
    );

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                if (32'(r_clr_cnt) == CLR_N - 1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    if (in_bad)                     n_state = S_RES;
                    else if (i_opcode != OP_NONE)   n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) n_state = (r_op == OP_WRITE) ? S_WRD : S_BLK;
            end
            S_WRD:  n_state = S_WWR;
            S_WWR:  n_state = S_IDLE;
            S_BLK:  n_state = S_BRD;
            S_BRD: begin
                if (!r_full)              n_state = S_ELEM;
                else if (r_op == OP_ADD)  n_state = S_BWR;
                else                      n_state = S_NEXT;
            end
            S_ELEM: begin
                if (r_i == r_hi) n_state = S_DRN;
            end
            S_DRN:  n_state = (r_op == OP_ADD) ? S_BWR : S_NEXT;
            S_BWR:  n_state = S_NEXT;
            S_NEXT: begin
                if (next_start > r_r) n_state = (r_op == OP_SUM) ? S_RES : S_IDLE;
                else                  n_state = S_BLK;
            end
            S_RES: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_CLR;
        endcase
        // A register write repartitions the array: clear everything.
        if (i_cfg_we) n_state = S_CLR;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr_cnt <= '0;
            r_alen    <= 11'd1024;
            r_bsz     <= 11'd32;
            r_ovalid  <= 1'b0;
            r_ev      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ev    <= (r_state == S_ELEM);
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_ARRAY_LENGTH) r_alen <= i_cfg_data;
                if (i_cfg_index == CFG_BLOCK_SIZE)   r_bsz  <= i_cfg_data;
                r_clr_cnt <= '0;
            end else if (r_state == S_CLR) begin
                r_clr_cnt <= r_clr_cnt + CW'(1);
            end
            if (out_load)          r_ovalid <= 1'b1;
            else if (i_ready)      r_ovalid <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_n  <= n_n;
        r_bs <= n_bs;
        if (accept) begin
            r_op      <= i_opcode;
            r_l       <= in_l;
            r_r       <= in_r;
            r_c       <= i_operand_value;
            r_acc     <= '0;
            r_res_sum <= '0;
            r_res_err <= in_bad;
        end
        if ((r_state == S_DIV) && div_rsp.done) begin
            r_blk   <= BW'(div_rsp.quot);
            r_start <= r_l - div_rsp.rem;
        end
        if (r_state == S_BLK) begin
            r_lo   <= blk_lo;
            r_hi   <= blk_hi;
            r_full <= blk_full;
            r_len  <= blk_full ? (blk_end - r_start + IW'(1)) : (blk_hi - blk_lo + IW'(1));
        end
        if (r_state == S_BRD) begin
            r_pend <= pend_rdata;
            r_sum  <= sum_rdata;
            r_prod <= {{(64-(IW+33)){prod[IW+32]}}, prod};
            r_i    <= r_lo;
            if (r_full && (r_op == OP_SUM)) r_acc <= r_acc + sum_rdata;
        end
        if (r_state == S_ELEM) begin
            r_i  <= r_i + IW'(1);
            r_ea <= AW'(r_i);
        end
        if (r_ev && (r_op == OP_SUM)) r_acc <= r_acc + elem_rdata + r_pend;
        if (r_state == S_NEXT) begin
            r_start <= next_start;
            r_blk   <= r_blk + BW'(1);
            if (r_op == OP_SUM) r_res_sum <= r_acc;
        end
        if (out_load) begin
            r_osum <= r_res_sum;
            r_oerr <= r_res_err;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_range_sum   = r_osum;
    assign o_range_error = r_oerr;

    // Streaming writes never hit the element being read in the same cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ev && (r_state == S_ELEM)) |-> (elem_waddr != elem_raddr))
        else $error("element write collides with read");

    // A bad request goes straight to the result stage.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && in_bad && !i_cfg_we) |=> (r_state == S_RES))
        else $error("bad request not reported");

    // A fresh result is only loaded from the result stage.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_RES))
        else $error("result loaded outside result stage");

    // No write is in flight when a request is accepted.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (!r_ev && !pend_we && !sum_we))
        else $error("request accepted with a store update pending");

endmodule

`default_nettype wire
